// ===== design/rlm_pkg.sv =====
`default_nettype none

package rlm_pkg;

    // Field widths fixed by the interface.
    localparam int SAMPLE_W = 16;
    localparam int COUNT_W  = 7;

    // One input transaction.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       keep;
        logic                       start_set;
    } in_t;

    // One result transaction.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] median;
        logic                       empty_res;
        logic [COUNT_W-1:0]         count;
        logic                       overflow;
    } out_t;

    // What one cell hands to its right-hand neighbor.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] val;
        logic                       gt;
    } link_t;

endpackage

`default_nettype wire

// ===== design/rlm_cell.sv =====
`default_nettype none

module rlm_cell #(
    parameter int IDX = 0,
    parameter int CW  = 7,
    parameter int IW  = 6
) (
    input  wire logic                                clk,
    input  wire logic                                ins_en,
    input  wire logic signed [rlm_pkg::SAMPLE_W-1:0] sample,
    input  wire logic [CW-1:0]                       eff_count,
    input  wire logic [IW-1:0]                       med_idx,
    input  wire rlm_pkg::link_t                      prev,
    output rlm_pkg::link_t                           link,
    output logic [rlm_pkg::SAMPLE_W-1:0]             sel_val
);
    import rlm_pkg::*;

    logic signed [SAMPLE_W-1:0] val_reg;
    logic signed [SAMPLE_W-1:0] val_next;
    logic                       gt;

    // Empty cells act as plus infinity; a sample above all stored ones fills the first free cell.
    assign gt = (CW'(IDX) >= eff_count) || (val_reg > sample);

    // Cells above the insertion point take the left neighbor; the insertion cell takes the sample.
    always_comb
    begin
        if (!gt)
            val_next = val_reg;
        else if (prev.gt)
            val_next = prev.val;
        else
            val_next = sample;
    end

    always_ff @(posedge clk)
    begin
        if (ins_en)
            val_reg <= val_next;
    end

    assign link.val = val_reg;
    assign link.gt  = gt;

    // Masked value for the median read-out; only the selected cell passes its value.
    assign sel_val = (med_idx == IW'(IDX)) ? val_reg : '0;

endmodule

`default_nettype wire

// ===== design/running_lower_median_top.sv =====
// An accepted transaction is registered in the pending slot and then in the result register, where result_valid rises.
// Throughput: one transaction per cycle while item_stall is low; the compare-and-shift cell chain inserts
// one sample per cycle and the median is read from the cells while the transaction waits in the pending slot.
// Reset clears the sample count, the overflow flag and all valid flags at once.
// The sample cells themselves are not cleared; only values of occupied cells reach the result.
`default_nettype none

module running_lower_median_top #(
    parameter int DEPTH = 64
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          item_valid,
    output logic               item_stall,
    input  wire rlm_pkg::in_t  item,
    output logic               result_valid,
    input  wire logic          result_stall,
    output rlm_pkg::out_t      result
);
    import rlm_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Snapshot of the bookkeeping for a transaction waiting for its median read.
    typedef struct packed {
        logic [IW-1:0] med_idx;
        logic          empty;
        logic [CW-1:0] count;
        logic          overflow;
    } pend_t;

    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic          pend_valid_reg, pend_valid_next;
    pend_t         pend_reg, pend_next;
    logic          out_valid_reg, out_valid_next;
    out_t          out_reg, out_next;

    logic          in_accept;
    logic          pend_move;
    logic [CW-1:0] eff_count;
    logic          ins_en;
    logic [CW-1:0] count_m1;

    link_t                 links [DEPTH+1];
    logic [SAMPLE_W-1:0]   sel_vals [DEPTH];
    logic [SAMPLE_W-1:0]   med_or;

    // Handshake control.
    assign pend_move  = pend_valid_reg && (!out_valid_reg || !result_stall);
    assign item_stall = pend_valid_reg && out_valid_reg && result_stall;
    assign in_accept  = item_valid && !item_stall;

    // Start of a new set clears the count before the sample is handled.
    assign eff_count = item.start_set ? '0 : count_reg;
    assign ins_en    = in_accept && item.keep && (eff_count < CW'(DEPTH));

    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (in_accept)
        begin
            count_next = eff_count + CW'(ins_en);
            ovf_next   = (item.start_set ? 1'b0 : ovf_reg)
                         || (item.keep && (eff_count == CW'(DEPTH)));
        end
    end

    // Median index (count - 1) / 2 of the updated set.
    assign count_m1 = count_next - CW'(1);

    always_comb
    begin
        pend_next          = pend_reg;
        pend_valid_next    = pend_valid_reg;
        if (pend_move)
            pend_valid_next = 1'b0;
        if (in_accept)
        begin
            pend_valid_next    = 1'b1;
            pend_next.med_idx  = IW'(count_m1 >> 1);
            pend_next.empty    = (count_next == '0);
            pend_next.count    = count_next;
            pend_next.overflow = ovf_next;
        end
    end

    // Cell chain; the leftmost neighbor is a virtual cell that is never greater.
    assign links[0].val = '0;
    assign links[0].gt  = 1'b0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        rlm_cell #(
            .IDX (i),
            .CW  (CW),
            .IW  (IW)
        ) u_cell (
            .clk       (clk),
            .ins_en    (ins_en),
            .sample    (item.sample),
            .eff_count (eff_count),
            .med_idx   (pend_reg.med_idx),
            .prev      (links[i]),
            .link      (links[i+1]),
            .sel_val   (sel_vals[i])
        );
    end

    // Only one cell passes a nonzero value, so an OR collects the median.
    always_comb
    begin
        med_or = '0;
        for (int i = 0; i < DEPTH; i++)
            med_or = med_or | sel_vals[i];
    end

    // Result register.
    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !result_stall)
            out_valid_next = 1'b0;
        if (pend_move)
        begin
            out_valid_next     = 1'b1;
            out_next.median    = pend_reg.empty ? '0 : med_or;
            out_next.empty_res = pend_reg.empty;
            out_next.count     = COUNT_W'(pend_reg.count);
            out_next.overflow  = pend_reg.overflow;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            ovf_reg        <= ovf_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // The store never holds more samples than it has cells.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("sample count exceeds store depth");

    // Input is held off only while both the pending slot and the result register are full.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (pend_valid_reg && out_valid_reg))
        else $error("input stalled with free pipeline space");

    // A new set without a kept sample reports an empty set.
    a_start_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && item.start_set && !item.keep) |=>
            (pend_valid_reg && pend_reg.empty && !pend_reg.overflow))
        else $error("cleared set not reported empty");

    // A pending transaction moves to the result register at the next edge.
    a_pend_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        pend_move |=> result_valid)
        else $error("pending result lost");

endmodule

`default_nettype wire
